// File: rtl/ild_pkg.sv
// ----------------------------------------------------------------------------
// ild_pkg
// Shared types and codes of the indexed list block: commands, status codes,
// control state and the per-cycle control word sent to every list cell.
// ----------------------------------------------------------------------------
package ild_pkg;

    localparam int unsigned ValueW = 32;
    localparam int unsigned PosW   = 8;
    localparam int unsigned ItemW  = 6;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SHOW   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_SHOW
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [PosW-1:0]   pos;
    } t_cell_ctrl;

endpackage

// File: rtl/ild_cell.sv
// ----------------------------------------------------------------------------
// ild_cell
// One list entry. Depending on the broadcast control word it keeps its value,
// takes the new value, or takes the value of its left or right neighbor.
// ----------------------------------------------------------------------------
module ild_cell
    import ild_pkg::*;
#(
    parameter int unsigned INDEX = 0
) (
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [ValueW-1:0] i_value,
    input  logic signed [ValueW-1:0] i_left,
    input  logic signed [ValueW-1:0] i_right,
    output logic signed [ValueW-1:0] o_data
);

    localparam logic [PosW-1:0] Idx = PosW'(INDEX);

    logic signed [ValueW-1:0] r_data;
    logic signed [ValueW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (Idx == i_ctrl.pos) begin
                    n_data = i_value;
                end else if (Idx > i_ctrl.pos) begin
                    n_data = i_left;
                end
            end
            OP_DELETE: begin
                if (Idx >= i_ctrl.pos) begin
                    n_data = i_right;
                end
            end
            OP_ROTATE: begin
                n_data = i_right;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/indexed_list_insert_delete.sv
// An insert or delete updates the cells when it is accepted; its status request
// appears on the output register the cycle after it is accepted.
// Insert, delete, unused commands and empty displays do not hold off the next
// command unless the output side stalls; a display holds off new commands through
// acceptance and one full rotation of the cell ring, longer if the output stalls.
// Reset: synchronous, active low; clears the count and control, entries stay.
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of up to CAPACITY signed values held in a ring of cells.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete
    import ild_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_cmd,
    input  logic signed [ValueW-1:0] i_value,
    input  logic [PosW-1:0]          i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic signed [ValueW-1:0] o_item_value,
    output logic [ItemW-1:0]         o_item_position,
    output logic                     o_last
);

    localparam int unsigned CntW = $clog2(CAPACITY + 1);
    localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);
    localparam logic [CntW-1:0] StepEnd = CntW'(CAPACITY - 1);

    // Control state.
    t_state          r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_step,  n_step;
    logic            r_out_valid, n_out_valid;

    // Output payload register.
    logic [1:0]               r_status,   n_status;
    logic signed [ValueW-1:0] r_item_val, n_item_val;
    logic [ItemW-1:0]         r_item_pos, n_item_pos;
    logic                     r_last,     n_last;

    t_cell_ctrl               cell_ctrl;
    logic signed [ValueW-1:0] cell_data [CAPACITY];
    logic                     out_free;
    logic                     in_acc;
    logic                     load_out;
    logic [PosW-1:0]          count_ext;

    // The output register can take a new request when it is empty or its
    // current request leaves this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign count_ext  = PosW'(r_count);

    // The cells form a ring: the last cell's right neighbor is cell zero, so
    // a display rotates the whole list once and leaves it where it started.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ild_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (cell_ctrl),
            .i_value(i_value),
            .i_left (cell_data[(g + CAPACITY - 1) % CAPACITY]),
            .i_right(cell_data[(g + 1) % CAPACITY]),
            .o_data (cell_data[g])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == CMD_SHOW) && (r_count != '0)) begin
                    n_state = S_SHOW;
                end
            end
            S_SHOW: begin
                if (out_free && (r_step == StepEnd)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Cell control, count, step and output register loads.
    always_comb begin
        cell_ctrl.op  = OP_HOLD;
        cell_ctrl.pos = i_position;
        n_count       = r_count;
        n_step        = r_step;
        load_out      = 1'b0;
        n_status      = ST_OK;
        n_item_val    = '0;
        n_item_pos    = '0;
        n_last        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (in_acc) begin
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            load_out = 1'b1;
                            if (r_count == CntFull) begin
                                n_status = ST_FULL;
                            end else if (i_position > count_ext) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                cell_ctrl.op = OP_INSERT;
                                n_count      = r_count + 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            load_out = 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (i_position >= count_ext) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                cell_ctrl.op = OP_DELETE;
                                n_count      = r_count - 1'b1;
                            end
                        end
                        CMD_SHOW: begin
                            // An empty list answers with a single status request.
                            if (r_count == '0) begin
                                load_out = 1'b1;
                                n_status = ST_EMPTY;
                            end
                        end
                        default: begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            S_SHOW: begin
                // Each advance emits cell zero while the step is below the
                // count, then rotates the ring by one place.
                if (out_free) begin
                    cell_ctrl.op = OP_ROTATE;
                    n_step       = r_step + 1'b1;
                    if (r_step < r_count) begin
                        load_out   = 1'b1;
                        n_item_val = cell_data[0];
                        n_item_pos = ItemW'(r_step);
                        n_last     = (r_step == (r_count - 1'b1));
                    end
                end
            end
            default: begin
                n_step = '0;
            end
        endcase
        n_out_valid = load_out ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status   <= n_status;
            r_item_val <= n_item_val;
            r_item_pos <= n_item_pos;
            r_last     <= n_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_item_value    = r_item_val;
    assign o_item_position = r_item_pos;
    assign o_last          = r_last;

endmodule
